// ===== rtl/dnsqe_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsqe_pkg
// Shared types and constants for the DNS question name encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsqe_pkg;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_QUERY_TYPE  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_QUERY_CLASS = 8'd1;

	// Special characters of the dotted name
	localparam logic [7:0] CHAR_DOT = 8'd46;
	localparam logic [7:0] CHAR_END = 8'd0;

	// Byte sequencer phases
	typedef enum logic [2:0] {
		G_IDLE,
		G_LEN,
		G_DATA,
		G_ROOT,
		G_TYPE_HI,
		G_TYPE_LO,
		G_CLASS_HI,
		G_CLASS_LO
	} gen_state_t;

	// One encoded byte on its way to the packer
	typedef struct packed {
		logic [7:0] data;
		logic       last;   // last byte caused by the input item
		logic       done;   // byte belongs to a finished question
	} enc_byte_t;

endpackage

`default_nettype wire

// ===== rtl/dnsqe_ram.sv =====
// ----------------------------------------------------------------------------
// dnsqe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsqe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/dnsqe_packer.sv =====
// ----------------------------------------------------------------------------
// dnsqe_packer
// Pairs encoded bytes into two-byte result items behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsqe_packer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	input  wire dnsqe_pkg::enc_byte_t byte_in,
	output      logic                 byte_take,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic [7:0]           first_byte,
	output      logic [7:0]           second_byte,
	output      logic                 second_valid,
	output      logic                 run_last,
	output      logic                 question_done
);

	logic       pend_q;
	logic [7:0] pend_byte_q;
	logic       out_valid_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic       second_valid_q;
	logic       run_last_q;
	logic       done_q;
	logic       out_free;
	logic       emit;

	assign out_free  = !out_valid_q || !out_stall;
	// A held first byte always needs the output; a lone first byte only if it ends the run.
	assign byte_take = byte_valid && (pend_q ? out_free : (!byte_in.last || out_free));
	assign emit      = byte_take && (pend_q || byte_in.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (byte_take) begin
				pend_q <= !pend_q && !byte_in.last;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take && !pend_q) begin
			pend_byte_q <= byte_in.data;
		end
		if (emit) begin
			first_q        <= pend_q ? pend_byte_q : byte_in.data;
			second_q       <= pend_q ? byte_in.data : 8'd0;
			second_valid_q <= pend_q;
			run_last_q     <= byte_in.last;
			done_q         <= byte_in.last && byte_in.done;
		end
	end

	assign out_valid     = out_valid_q;
	assign first_byte    = first_q;
	assign second_byte   = second_q;
	assign second_valid  = second_valid_q;
	assign run_last      = run_last_q;
	assign question_done = done_q;

endmodule

`default_nettype wire

// ===== rtl/dns_question_name_encoder_core.sv =====
// ----------------------------------------------------------------------------
// dns_question_name_encoder_core
// Encodes a dotted domain name, one character per item, into DNS question form.
// ----------------------------------------------------------------------------
// An ordinary character is stored while the label has room and gives no result.
// A dot keeps the input stalled while its label is read out, and a terminator
// also while the root, type and class bytes follow; label bytes leave the RAM's
// single read port one per cycle while the packer takes them. Each byte passes
// from the sequencer through the stage-1 register to the packer, whose output
// register holds the result items. Reset clears the count, sequencer and output
// register and sets both query codes to 1; the label RAM needs no clearing pass.
`default_nettype none

module dns_question_name_encoder_core #(
	parameter int LABEL_MAX = 63
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// character input
	input  wire logic                                 in_valid,
	output      logic                                 in_stall,
	input  wire logic [7:0]                           name_char,
	// encoded output
	output      logic                                 out_valid,
	input  wire logic                                 out_stall,
	output      logic [7:0]                           first_byte,
	output      logic [7:0]                           second_byte,
	output      logic                                 second_valid,
	output      logic                                 run_last,
	output      logic                                 question_done,
	// configuration writes
	input  wire logic                                 cfg_valid,
	output      logic                                 cfg_ready,
	input  wire logic [dnsqe_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [dnsqe_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Count width holds LABEL_MAX itself; the address width covers the RAM depth.
	localparam int CW = $clog2(LABEL_MAX + 1);
	localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

	// Configuration registers. The port never holds a write off.
	logic [15:0] query_type_q;
	logic [15:0] query_class_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_type_q  <= 16'd1;
			query_class_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dnsqe_pkg::REG_QUERY_TYPE:  query_type_q  <= cfg_data;
				dnsqe_pkg::REG_QUERY_CLASS: query_class_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer state. While a label is being read out the input is stalled,
	// so the RAM write port (filling) and read port (emptying) never overlap.
	dnsqe_pkg::gen_state_t state_q, state_d;
	logic [CW-1:0] count_q;      // characters held for the label being filled
	logic [CW-1:0] run_cnt_q;    // length of the label being read out
	logic [CW-1:0] idx_q;        // next label byte to read
	logic          run_done_q;   // current run was started by the terminator

	logic in_accept;
	logic is_dot;
	logic is_end;
	logic advance;
	logic idx_is_last;

	// Descriptor of the byte produced this cycle by the sequencer
	logic       gen_ram;
	logic [7:0] gen_data;
	logic       gen_last;

	// Stage 1: byte waiting for the packer; label bytes come from RAM read data.
	logic       s1_valid_s1;
	logic       ram_sel_s1;
	logic [7:0] const_s1;
	logic       last_s1;
	logic       done_s1;

	logic                  ram_we;
	logic                  ram_re;
	logic [7:0]            ram_rdata;
	logic                  byte_take;
	dnsqe_pkg::enc_byte_t  byte_s1;

	assign in_stall    = (state_q != dnsqe_pkg::G_IDLE);
	assign in_accept   = in_valid && !in_stall;
	assign is_dot      = (name_char == dnsqe_pkg::CHAR_DOT);
	assign is_end      = (name_char == dnsqe_pkg::CHAR_END);
	assign advance     = !s1_valid_s1 || byte_take;
	assign idx_is_last = ((idx_q + CW'(1)) == run_cnt_q);

	// An ordinary character is kept only while the label has room; beyond that
	// it is dropped without trace.
	assign ram_we = in_accept && !is_dot && !is_end && (count_q < CW'(LABEL_MAX));
	assign ram_re = advance && (state_q == dnsqe_pkg::G_DATA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dnsqe_pkg::G_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		gen_ram  = 1'b0;
		gen_data = 8'd0;
		gen_last = 1'b0;
		unique case (state_q)
			dnsqe_pkg::G_IDLE: begin
				if (in_accept && is_dot) begin
					state_d = dnsqe_pkg::G_LEN;
				end else if (in_accept && is_end) begin
					// A terminator with nothing pending goes straight to the root byte.
					state_d = (count_q != '0) ? dnsqe_pkg::G_LEN : dnsqe_pkg::G_ROOT;
				end
			end
			dnsqe_pkg::G_LEN: begin
				gen_data = 8'(run_cnt_q);
				// An empty label from a dot is a lone zero length byte.
				gen_last = !run_done_q && (run_cnt_q == '0);
				if (advance) begin
					if (run_cnt_q != '0) begin
						state_d = dnsqe_pkg::G_DATA;
					end else begin
						state_d = run_done_q ? dnsqe_pkg::G_ROOT : dnsqe_pkg::G_IDLE;
					end
				end
			end
			dnsqe_pkg::G_DATA: begin
				gen_ram  = 1'b1;
				gen_last = !run_done_q && idx_is_last;
				if (advance && idx_is_last) begin
					state_d = run_done_q ? dnsqe_pkg::G_ROOT : dnsqe_pkg::G_IDLE;
				end
			end
			dnsqe_pkg::G_ROOT: begin
				gen_data = 8'd0;
				if (advance) begin
					state_d = dnsqe_pkg::G_TYPE_HI;
				end
			end
			dnsqe_pkg::G_TYPE_HI: begin
				gen_data = query_type_q[15:8];
				if (advance) begin
					state_d = dnsqe_pkg::G_TYPE_LO;
				end
			end
			dnsqe_pkg::G_TYPE_LO: begin
				gen_data = query_type_q[7:0];
				if (advance) begin
					state_d = dnsqe_pkg::G_CLASS_HI;
				end
			end
			dnsqe_pkg::G_CLASS_HI: begin
				gen_data = query_class_q[15:8];
				if (advance) begin
					state_d = dnsqe_pkg::G_CLASS_LO;
				end
			end
			dnsqe_pkg::G_CLASS_LO: begin
				gen_data = query_class_q[7:0];
				gen_last = 1'b1;
				if (advance) begin
					state_d = dnsqe_pkg::G_IDLE;
				end
			end
			default: begin
				state_d = dnsqe_pkg::G_IDLE;
			end
		endcase
	end

	// Label bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			run_cnt_q  <= '0;
			idx_q      <= '0;
			run_done_q <= 1'b0;
		end else begin
			if (in_accept && (is_dot || is_end)) begin
				run_cnt_q  <= count_q;
				run_done_q <= is_end;
				idx_q      <= '0;
				count_q    <= '0;
			end else if (ram_we) begin
				count_q <= count_q + CW'(1);
			end
			if (ram_re) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// Stage 1 register. It only moves on when the packer has taken its byte,
	// and the RAM read data stays put with it since no new read is issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (advance) begin
			s1_valid_s1 <= (state_q != dnsqe_pkg::G_IDLE);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ram_sel_s1 <= gen_ram;
			const_s1   <= gen_data;
			last_s1    <= gen_last;
			done_s1    <= run_done_q;
		end
	end

	dnsqe_ram #(
		.WIDTH (8),
		.DEPTH (LABEL_MAX)
	) u_label_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (name_char),
		.re    (ram_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign byte_s1.data = ram_sel_s1 ? ram_rdata : const_s1;
	assign byte_s1.last = last_s1;
	assign byte_s1.done = done_s1;

	dnsqe_packer u_packer (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (s1_valid_s1),
		.byte_in       (byte_s1),
		.byte_take     (byte_take),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.first_byte    (first_byte),
		.second_byte   (second_byte),
		.second_valid  (second_valid),
		.run_last      (run_last),
		.question_done (question_done)
	);

endmodule

`default_nettype wire

// ===== rtl/dnsqe_checker.sv =====
// ----------------------------------------------------------------------------
// dnsqe_checker
// Port-level checks on the DNS question name encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsqe_port_checks (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] name_char,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] first_byte,
	input wire logic [7:0] second_byte,
	input wire logic       second_valid,
	input wire logic       run_last,
	input wire logic       question_done
);

	// A stalled item holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(first_byte)
			&& $stable(second_byte) && $stable(second_valid)
			&& $stable(run_last) && $stable(question_done))
		else $error("stalled output item changed");

	// The end of a question is always the end of its run.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && question_done |-> run_last)
		else $error("question_done without run_last");

	// A half-filled item only closes a run.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !second_valid |-> run_last && (second_byte == 8'd0))
		else $error("single-byte item inside a run");

	// A separator or terminator starts a read-out, which holds the input off.
	a_sep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && ((name_char == dnsqe_pkg::CHAR_END)
			|| (name_char == dnsqe_pkg::CHAR_DOT))
			|=> in_stall)
		else $error("input not stalled after a separator");

endmodule

bind dns_question_name_encoder_core dnsqe_port_checks u_dnsqe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.name_char     (name_char),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.first_byte    (first_byte),
	.second_byte   (second_byte),
	.second_valid  (second_valid),
	.run_last      (run_last),
	.question_done (question_done)
);

`default_nettype wire
